/* rtl/bmw_pkg.sv */
package bmw_pkg;

    // Widest table index: up to 16 direct slots plus three indirect roots.
    localparam int SLOT_W = 5;

    localparam logic [3:0] PLOG2_MIN = 4'd8;
    localparam logic [3:0] PLOG2_MAX = 4'd14;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_WORD   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_REQUEST   = 2'd0,
        KIND_ANSWER    = 2'd1,
        KIND_TOO_LARGE = 2'd2
    } kind_t;

    // Work for the back end, already classified by the front end.
    typedef enum logic [2:0] {
        OP_LOAD      = 3'd0,
        OP_DIRECT    = 3'd1,
        OP_TOO_LARGE = 3'd2,
        OP_WALK      = 3'd3,
        OP_WORD      = 3'd4
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] slot;   // table slot to read or write
        logic [1:0]        level;  // indirection depth of a new walk
        logic [31:0]       data;   // load value, returned word, or walk offset
    } entry_t;

    function automatic logic [3:0] eff_log2(input logic [3:0] raw);
        logic [3:0] p;
        p = raw;
        if (raw < PLOG2_MIN)
        begin
            p = PLOG2_MIN;
        end
        else if (raw > PLOG2_MAX)
        begin
            p = PLOG2_MAX;
        end
        return p;
    endfunction

    // Pointer index within a block, with 'remaining' levels still to go.
    function automatic logic [13:0] level_index(input logic [31:0] off,
                                                input logic [3:0]  p,
                                                input logic [1:0]  remaining);
        logic [4:0]  sh;
        logic [31:0] shifted;
        logic [14:0] mask;
        unique case (remaining)
            2'd2:    sh = 5'(p);
            2'd3:    sh = {p, 1'b0};
            default: sh = 5'd0;
        endcase
        shifted = off >> sh;
        mask    = (15'd1 << p) - 15'd1;
        return shifted[13:0] & mask[13:0];
    endfunction

endpackage

/* rtl/bmw_front.sv */
module bmw_front #(
    parameter int DIRECT_COUNT = 12
) (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [3:0]           slot,
    input  logic [31:0]          value,
    input  logic [31:0]          file_block,
    input  logic [3:0]           plog2,
    input  logic                 q_full,
    output logic                 push,
    output bmw_pkg::entry_t      push_entry
);

    localparam int SLOT_COUNT = DIRECT_COUNT + 3;

    logic [31:0] off;
    logic [5:0]  sh2;
    logic [5:0]  sh3;
    logic [43:0] span1;
    logic [43:0] span2;
    logic [43:0] span3;
    logic [43:0] off_w;
    logic [43:0] rem2;
    logic [43:0] rem3;
    logic        keep;

    // Region split: single, double, triple indirect, else past the end.
    assign off   = file_block - 32'(DIRECT_COUNT);
    assign sh2   = {1'b0, plog2, 1'b0};
    assign sh3   = {1'b0, plog2, 1'b0} + {2'b00, plog2};
    assign span1 = 44'd1 << plog2;
    assign span2 = 44'd1 << sh2;
    assign span3 = 44'd1 << sh3;
    assign off_w = {12'd0, off};
    assign rem2  = off_w - span1;
    assign rem3  = rem2 - span2;

    always_comb
    begin
        keep             = 1'b1;
        push_entry.op    = bmw_pkg::OP_LOAD;
        push_entry.slot  = {1'b0, slot};
        push_entry.level = 2'd0;
        push_entry.data  = value;
        unique case (bmw_pkg::action_t'(action))
            bmw_pkg::ACT_LOAD:
            begin
                keep = ({1'b0, slot} < bmw_pkg::SLOT_W'(SLOT_COUNT));
            end
            bmw_pkg::ACT_LOOKUP:
            begin
                if (file_block < 32'(DIRECT_COUNT))
                begin
                    push_entry.op   = bmw_pkg::OP_DIRECT;
                    push_entry.slot = file_block[bmw_pkg::SLOT_W-1:0];
                end
                else if (off_w < span1)
                begin
                    push_entry.op    = bmw_pkg::OP_WALK;
                    push_entry.slot  = bmw_pkg::SLOT_W'(DIRECT_COUNT);
                    push_entry.level = 2'd1;
                    push_entry.data  = off;
                end
                else if (rem2 < span2)
                begin
                    push_entry.op    = bmw_pkg::OP_WALK;
                    push_entry.slot  = bmw_pkg::SLOT_W'(DIRECT_COUNT + 1);
                    push_entry.level = 2'd2;
                    push_entry.data  = rem2[31:0];
                end
                else if (rem3 < span3)
                begin
                    push_entry.op    = bmw_pkg::OP_WALK;
                    push_entry.slot  = bmw_pkg::SLOT_W'(DIRECT_COUNT + 2);
                    push_entry.level = 2'd3;
                    push_entry.data  = rem3[31:0];
                end
                else
                begin
                    push_entry.op = bmw_pkg::OP_TOO_LARGE;
                end
            end
            bmw_pkg::ACT_WORD:
            begin
                push_entry.op = bmw_pkg::OP_WORD;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full && keep;

endmodule

/* rtl/bmw_queue.sv */
module bmw_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bmw_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output bmw_pkg::entry_t  pop_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bmw_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue push lost");
`endif

endmodule

/* rtl/bmw_back.sv */
module bmw_back #(
    parameter int DIRECT_COUNT = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  bmw_pkg::entry_t  q_entry,
    output logic             q_pop,
    input  logic [3:0]       plog2,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [31:0]      block,
    output logic [13:0]      word_index
);

    localparam int SLOT_COUNT = DIRECT_COUNT + 3;
    localparam int IDX_W      = $clog2(SLOT_COUNT);

    logic [31:0]           table_reg [SLOT_COUNT];
    logic [31:0]           offset_reg;
    logic [31:0]           offset_next;
    logic [1:0]            level_reg;
    logic [1:0]            level_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    bmw_pkg::kind_t        kind_reg;
    bmw_pkg::kind_t        kind_next;
    logic [31:0]           block_reg;
    logic [31:0]           block_next;
    logic [13:0]           word_index_reg;
    logic [13:0]           word_index_next;
    logic                  take;
    logic                  emit;
    logic                  table_we;
    logic [IDX_W-1:0]      idx;
    logic [31:0]           rd_data;

    assign take    = q_valid && (!out_valid_reg || out_ready);
    assign q_pop   = take;
    assign idx     = q_entry.slot[IDX_W-1:0];
    assign rd_data = table_reg[idx];

    always_comb
    begin
        offset_next     = offset_reg;
        level_next      = level_reg;
        emit            = 1'b0;
        table_we        = 1'b0;
        kind_next       = bmw_pkg::KIND_ANSWER;
        block_next      = 32'd0;
        word_index_next = 14'd0;
        if (take)
        begin
            unique case (q_entry.op)
                bmw_pkg::OP_LOAD:
                begin
                    table_we = 1'b1;
                end
                bmw_pkg::OP_DIRECT:
                begin
                    emit       = 1'b1;
                    block_next = rd_data;
                    level_next = 2'd0;
                end
                bmw_pkg::OP_TOO_LARGE:
                begin
                    emit       = 1'b1;
                    kind_next  = bmw_pkg::KIND_TOO_LARGE;
                    level_next = 2'd0;
                end
                bmw_pkg::OP_WALK:
                begin
                    emit       = 1'b1;
                    level_next = 2'd0;
                    // zero root pointer: hole, answer zero
                    if (rd_data != 32'd0)
                    begin
                        kind_next       = bmw_pkg::KIND_REQUEST;
                        block_next      = rd_data;
                        word_index_next = bmw_pkg::level_index(q_entry.data, plog2,
                                                               q_entry.level);
                        offset_next     = q_entry.data;
                        level_next      = q_entry.level;
                    end
                end
                bmw_pkg::OP_WORD:
                begin
                    // a word with no walk in progress is dropped
                    if (level_reg != 2'd0)
                    begin
                        emit = 1'b1;
                        if (level_reg == 2'd1 || q_entry.data == 32'd0)
                        begin
                            block_next = q_entry.data;
                            level_next = 2'd0;
                        end
                        else
                        begin
                            kind_next       = bmw_pkg::KIND_REQUEST;
                            block_next      = q_entry.data;
                            level_next      = level_reg - 2'd1;
                            word_index_next = bmw_pkg::level_index(offset_reg, plog2,
                                                                   level_reg - 2'd1);
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        out_valid_next = take ? emit : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                table_reg[i] <= 32'd0;
            end
            offset_reg    <= 32'd0;
            level_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (table_we)
            begin
                table_reg[idx] <= q_entry.data;
            end
            offset_reg    <= offset_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            kind_reg       <= kind_next;
            block_reg      <= block_next;
            word_index_reg <= word_index_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign block      = block_reg;
    assign word_index = word_index_reg;

`ifndef NO_ASSERTIONS
    a_request_has_walk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == bmw_pkg::KIND_REQUEST |-> level_reg != 2'd0)
        else $error("read request with no walk in progress");
    a_answer_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != bmw_pkg::KIND_REQUEST |-> level_reg == 2'd0)
        else $error("walk still open after final result");
    a_index_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != bmw_pkg::KIND_REQUEST |-> word_index_reg == 14'd0)
        else $error("word index on non-request result");
`endif

endmodule

/* rtl/block_map_walker.sv */
// Logical-to-physical block lookup for an inode-style map: direct pointers
// plus single, double and triple indirect roots, loaded one slot at a time.
// A lookup answers at once (direct slot, zero root, or too-large error) or
// issues one read request per indirection level; each returned pointer word
// (action 2) produces the next request or the final answer. Throughput is one
// transaction per cycle while out_ready is high, limited by the single output
// register of the walk engine; each input passes the classifier into a small
// queue, then the walk engine's table read into the output register. The
// input side keeps accepting while a result waits, until the queue fills.
// pointers_log2 is clamped to 8..14 and may be rewritten between walks.
module block_map_walker #(
    parameter int DIRECT_COUNT = 12,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [3:0]  slot,
    input  logic [31:0] value,
    input  logic [31:0] file_block,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] block,
    output logic [13:0] word_index
);

    localparam logic REG_POINTERS_LOG2 = 1'b0;

    logic [3:0]       plog2_reg;
    logic [3:0]       plog2_next;
    logic [3:0]       plog2_eff;
    logic             cfg_write;
    logic             q_full;
    logic             q_push;
    logic             q_valid;
    logic             q_pop;
    bmw_pkg::entry_t  push_entry;
    bmw_pkg::entry_t  pop_entry;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign plog2_next = (cfg_write && paddr[2] == REG_POINTERS_LOG2) ? pwdata[3:0]
                                                                     : plog2_reg;
    assign prdata     = (paddr[2] == REG_POINTERS_LOG2) ? {28'd0, plog2_reg} : 32'd0;
    assign plog2_eff  = bmw_pkg::eff_log2(plog2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plog2_reg <= bmw_pkg::PLOG2_MIN;
        end
        else
        begin
            plog2_reg <= plog2_next;
        end
    end

    bmw_front #(
        .DIRECT_COUNT (DIRECT_COUNT)
    ) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .slot          (slot),
        .value         (value),
        .file_block    (file_block),
        .plog2         (plog2_eff),
        .q_full        (q_full),
        .push          (q_push),
        .push_entry    (push_entry)
    );

    bmw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .pop_entry  (pop_entry)
    );

    bmw_back #(
        .DIRECT_COUNT (DIRECT_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (pop_entry),
        .q_pop      (q_pop),
        .plog2      (plog2_eff),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .block      (block),
        .word_index (word_index)
    );

endmodule
